FILE: rtl/dxpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxpid_pkg
// Shared constants and helper functions for the three-axis velocity controller.
// ----------------------------------------------------------------------------
package dxpid_pkg;

  // cordic start value (gain-compensated 1.0 in q2.30)
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // heading constants in q3.13
  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

  // integrator range, signed 48 bits
  localparam logic signed [48:0] SUM_MAX = 49'sd140737488355327;
  localparam logic signed [48:0] SUM_MIN = -49'sd140737488355328;

  // pid term saturation value and product limit
  localparam logic signed [49:0] TERM_SAT = 50'sd70368744177664;
  localparam logic [74:0] PROD_LIM = 75'd4611686018427387904;

  // iteration counts
  localparam int CORDIC_ITERS = 16;
  localparam int SQRT_ITERS   = 32;
  localparam int DIV_ITERS    = 56;

  // arctangent table in q.16
  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/drone_xyz_pid_velocity_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drone_xyz_pid_velocity_controller
// Three-axis pid velocity controller with a world-to-body yaw rotation.
// ----------------------------------------------------------------------------
// One input beat is handled at a time. A beat with zero elapsed time returns
// the last commands in the cycle after it is taken. Any other beat runs 16
// cordic steps and three passes of a 56-step restoring divider (the three
// derivatives), plus the pid terms on one shared 33x33 multiplier; when the
// body y error is not zero it also runs 32 square-root steps and two more
// divider passes (the two planar shares). The result register frees the core,
// but a new beat is taken only once the last result has been taken.
module drone_xyz_pid_velocity_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_goal_x,
  input  logic signed [31:0] in_goal_y,
  input  logic signed [31:0] in_goal_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_heading,
  input  logic        [15:0] in_elapsed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_vel_x_cmd,
  output logic signed [31:0] out_vel_y_cmd,
  output logic signed [31:0] out_vel_z_cmd,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [23:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CORD, ST_ROT0, ST_ROT1, ST_ROT2, ST_ROT3, ST_ROT4, ST_ROT5,
    ST_ROT6, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT, ST_SH0, ST_SH1, ST_SH2,
    ST_SH3, ST_SH4, ST_PID0, ST_PID1, ST_TRM0, ST_TRM1, ST_TRM2, ST_TRM3,
    ST_TRM4, ST_PIDEND, ST_DIV
  } state_t;

  typedef enum logic [1:0] {AXIS_Z, AXIS_X, AXIS_Y} axis_t;

  localparam logic [2:0] REG_KP_PL = 3'd0;
  localparam logic [2:0] REG_KI_PL = 3'd1;
  localparam logic [2:0] REG_KD_PL = 3'd2;
  localparam logic [2:0] REG_KP_VT = 3'd3;
  localparam logic [2:0] REG_KI_VT = 3'd4;
  localparam logic [2:0] REG_KD_VT = 3'd5;
  localparam logic [2:0] REG_LIM_PL = 3'd6;
  localparam logic [2:0] REG_LIM_VT = 3'd7;

  // configuration registers
  logic [23:0] kp_pl_r, ki_pl_r, kd_pl_r, kp_vt_r, ki_vt_r, kd_vt_r;
  logic [23:0] lim_pl_r, lim_vt_r;

  // control
  state_t            state_r, ret_r;
  axis_t             axis_r;
  logic [1:0]        tk_r;
  logic [5:0]        cnt_r;
  logic              out_valid_r;

  // controller state
  logic              first_r;
  logic signed [31:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [47:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [31:0] cmd_x_r, cmd_y_r, cmd_z_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;

  // datapath
  logic [15:0]        dt_r;
  logic signed [31:0] dx_r, dy_r, ez_r, ex_r, ey_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [19:0] cz_r;
  logic               neg_r;
  logic signed [32:0] c_r, s_r;
  logic signed [32:0] ma_r, mb_r;
  logic signed [65:0] prod_r;
  logic signed [66:0] acc_r;
  logic [31:0]        ax_r, ay_r;
  logic [63:0]        rad_r, res_r, bit_r;
  logic [23:0]        shx_r, shy_r;
  logic [31:0]        rem_r, dvs_r;
  logic [55:0]        quo_r;
  logic               dneg_r;
  logic signed [49:0] deriv_r;
  logic               aneg_r;
  logic [24:0]        maghi_r;
  logic [48:0]        pl_r;
  logic [74:0]        pp_r;
  logic signed [49:0] u_r;

  // accept-cycle logic
  logic               acc_in;
  logic signed [32:0] ddx, ddy, ddz;
  logic signed [17:0] a0, a1, a2, a3;
  logic               fold;

  // cordic step
  logic signed [33:0] xs, ys;

  // pid selection
  logic signed [31:0] err_sel, prev_sel;
  logic signed [47:0] sum_sel;
  logic [23:0]        kp_sel, ki_sel, kd_sel, lim_sel, k_sel;
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  logic signed [48:0] sum_ext, sum_cl;
  logic signed [49:0] op_a;
  logic [49:0]        op_mag;
  logic signed [63:0] pos_v;
  logic signed [63:0] tv;
  logic signed [49:0] term_v;
  logic signed [49:0] lim_ext;
  logic signed [31:0] u_cl;

  // divider and square-root steps
  logic [32:0]        dtry;
  logic [33:0]        dsub;
  logic               dge;
  logic [63:0]        tsum;
  logic               sge;

  assign in_ready      = (state_r == ST_IDLE) && !out_valid_r;
  assign acc_in        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_vel_x_cmd = out_x_r;
  assign out_vel_y_cmd = out_y_r;
  assign out_vel_z_cmd = out_z_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_pl_r  <= 24'd65536;
      ki_pl_r  <= 24'd0;
      kd_pl_r  <= 24'd0;
      kp_vt_r  <= 24'd65536;
      ki_vt_r  <= 24'd0;
      kd_vt_r  <= 24'd0;
      lim_pl_r <= 24'd131072;
      lim_vt_r <= 24'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_PL:  kp_pl_r  <= cfg_data;
        REG_KI_PL:  ki_pl_r  <= cfg_data;
        REG_KD_PL:  kd_pl_r  <= cfg_data;
        REG_KP_VT:  kp_vt_r  <= cfg_data;
        REG_KI_VT:  ki_vt_r  <= cfg_data;
        REG_KD_VT:  kd_vt_r  <= cfg_data;
        REG_LIM_PL: lim_pl_r <= cfg_data;
        REG_LIM_VT: lim_vt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier, operands and product registered
  always_ff @(posedge clk) begin
    prod_r <= ma_r * mb_r;
  end

  // world errors and heading fold
  always_comb begin
    ddx = {in_goal_x[31], in_goal_x} - {in_pos_x[31], in_pos_x};
    ddy = {in_goal_y[31], in_goal_y} - {in_pos_y[31], in_pos_y};
    ddz = {in_goal_z[31], in_goal_z} - {in_pos_z[31], in_pos_z};
    a0 = 18'(in_heading);
    a1 = (a0 > dxpid_pkg::PI_Q13) ? a0 - dxpid_pkg::TWO_PI_Q13 : a0;
    a2 = (a1 < -dxpid_pkg::PI_Q13) ? a1 + dxpid_pkg::TWO_PI_Q13 : a1;
    fold = 1'b0;
    a3 = a2;
    if (a2 > dxpid_pkg::HALF_PI_Q13) begin
      a3 = a2 - dxpid_pkg::PI_Q13;
      fold = 1'b1;
    end else if (a2 < -dxpid_pkg::HALF_PI_Q13) begin
      a3 = a2 + dxpid_pkg::PI_Q13;
      fold = 1'b1;
    end
  end

  // cordic shifts
  always_comb begin
    xs = cx_r >>> cnt_r[3:0];
    ys = cy_r >>> cnt_r[3:0];
  end

  // pid operand selection and term arithmetic
  always_comb begin
    case (axis_r)
      AXIS_Z: begin
        err_sel  = ez_r;
        prev_sel = first_r ? ez_r : prev_z_r;
        sum_sel  = sum_z_r;
        kp_sel   = kp_vt_r;
        ki_sel   = ki_vt_r;
        kd_sel   = kd_vt_r;
        lim_sel  = lim_vt_r;
      end
      AXIS_X: begin
        err_sel  = ex_r;
        prev_sel = prev_x_r;
        sum_sel  = sum_x_r;
        kp_sel   = kp_pl_r;
        ki_sel   = ki_pl_r;
        kd_sel   = kd_pl_r;
        lim_sel  = shx_r;
      end
      default: begin
        err_sel  = ey_r;
        prev_sel = prev_y_r;
        sum_sel  = sum_y_r;
        kp_sel   = kp_pl_r;
        ki_sel   = ki_pl_r;
        kd_sel   = kd_pl_r;
        lim_sel  = shy_r;
      end
    endcase
    diff = {err_sel[31], err_sel} - {prev_sel[31], prev_sel};
    dmag = diff[32] ? 33'(-diff) : 33'(diff);
    sum_ext = 49'(sum_sel) + 49'(err_sel);
    if (sum_ext > dxpid_pkg::SUM_MAX) begin
      sum_cl = dxpid_pkg::SUM_MAX;
    end else if (sum_ext < dxpid_pkg::SUM_MIN) begin
      sum_cl = dxpid_pkg::SUM_MIN;
    end else begin
      sum_cl = sum_ext;
    end
    case (tk_r)
      2'd0: begin
        op_a  = 50'(err_sel);
        k_sel = kp_sel;
      end
      2'd1: begin
        op_a  = 50'(sum_sel);
        k_sel = ki_sel;
      end
      default: begin
        op_a  = deriv_r;
        k_sel = kd_sel;
      end
    endcase
    op_mag = op_a[49] ? 50'(-op_a) : 50'(op_a);
    // exact product is in pp_r; floor shift on the signed value
    pos_v = {1'b0, pp_r[62:0]};
    tv = aneg_r ? ((-pos_v) >>> 16) : (pos_v >>> 16);
    if (pp_r > dxpid_pkg::PROD_LIM) begin
      term_v = aneg_r ? -dxpid_pkg::TERM_SAT : dxpid_pkg::TERM_SAT;
    end else begin
      term_v = tv[49:0];
    end
    // output clamp
    lim_ext = {26'd0, lim_sel};
    if (u_r > lim_ext) begin
      u_cl = lim_ext[31:0];
    end else if (u_r < -lim_ext) begin
      u_cl = 32'(-lim_ext);
    end else begin
      u_cl = u_r[31:0];
    end
  end

  // divider and square-root steps
  always_comb begin
    dtry = {rem_r, quo_r[55]};
    dsub = {1'b0, dtry} - {2'b00, dvs_r};
    dge  = !dsub[33];
    tsum = res_r + bit_r;
    sge  = rad_r >= tsum;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      axis_r      <= AXIS_Z;
      tk_r        <= 2'd0;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      cmd_x_r     <= '0;
      cmd_y_r     <= '0;
      cmd_z_r     <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc_in) begin
            if (in_elapsed == 16'd0) begin
              out_x_r     <= cmd_x_r;
              out_y_r     <= cmd_y_r;
              out_z_r     <= cmd_z_r;
              out_valid_r <= 1'b1;
            end else begin
              dt_r    <= in_elapsed;
              dx_r    <= dxpid_pkg::sat32(67'(ddx));
              dy_r    <= dxpid_pkg::sat32(67'(ddy));
              ez_r    <= dxpid_pkg::sat32(67'(ddz));
              cx_r    <= dxpid_pkg::CORDIC_GAIN;
              cy_r    <= '0;
              cz_r    <= {a3[16:0], 3'b000};
              neg_r   <= fold;
              cnt_r   <= 6'd0;
              state_r <= ST_CORD;
            end
          end
        end
        // one rotation step a cycle
        ST_CORD: begin
          if (!cz_r[19]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - dxpid_pkg::atan_q16(cnt_r[3:0]);
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + dxpid_pkg::atan_q16(cnt_r[3:0]);
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(dxpid_pkg::CORDIC_ITERS - 1)) begin
            state_r <= ST_ROT0;
          end
        end
        // body-frame errors through the shared multiplier
        ST_ROT0: begin
          c_r     <= neg_r ? 33'(-cx_r) : 33'(cx_r);
          s_r     <= neg_r ? 33'(-cy_r) : 33'(cy_r);
          ma_r    <= neg_r ? 33'(-cx_r) : 33'(cx_r);
          mb_r    <= 33'(dx_r);
          state_r <= ST_ROT1;
        end
        ST_ROT1: begin
          ma_r    <= s_r;
          mb_r    <= 33'(dy_r);
          state_r <= ST_ROT2;
        end
        ST_ROT2: begin
          acc_r   <= 67'(prod_r);
          ma_r    <= c_r;
          mb_r    <= 33'(dy_r);
          state_r <= ST_ROT3;
        end
        ST_ROT3: begin
          acc_r   <= acc_r + 67'(prod_r);
          ma_r    <= s_r;
          mb_r    <= 33'(dx_r);
          state_r <= ST_ROT4;
        end
        ST_ROT4: begin
          ex_r    <= dxpid_pkg::sat32(acc_r >>> 30);
          acc_r   <= 67'(prod_r);
          state_r <= ST_ROT5;
        end
        ST_ROT5: begin
          acc_r   <= acc_r - 67'(prod_r);
          state_r <= ST_ROT6;
        end
        ST_ROT6: begin
          ey_r <= dxpid_pkg::sat32(acc_r >>> 30);
          ax_r <= ex_r[31] ? 32'(-ex_r) : 32'(ex_r);
          if (dxpid_pkg::sat32(acc_r >>> 30) == 32'sd0) begin
            shx_r   <= lim_pl_r;
            shy_r   <= 24'd0;
            axis_r  <= AXIS_Z;
            state_r <= ST_PID0;
          end else begin
            state_r <= ST_SQ0;
          end
        end
        // squared radius
        ST_SQ0: begin
          ay_r    <= ey_r[31] ? 32'(-ey_r) : 32'(ey_r);
          ma_r    <= {1'b0, ax_r};
          mb_r    <= {1'b0, ax_r};
          state_r <= ST_SQ1;
        end
        ST_SQ1: begin
          ma_r    <= {1'b0, ay_r};
          mb_r    <= {1'b0, ay_r};
          state_r <= ST_SQ2;
        end
        ST_SQ2: begin
          acc_r   <= 67'(prod_r);
          state_r <= ST_SQ3;
        end
        ST_SQ3: begin
          rad_r   <= acc_r[63:0] + prod_r[63:0];
          res_r   <= '0;
          bit_r   <= 64'h4000_0000_0000_0000;
          cnt_r   <= 6'd0;
          state_r <= ST_SQRT;
        end
        // digit-by-digit square root
        ST_SQRT: begin
          if (sge) begin
            rad_r <= rad_r - tsum;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(dxpid_pkg::SQRT_ITERS - 1)) begin
            state_r <= ST_SH0;
          end
        end
        // planar limit shares
        ST_SH0: begin
          ma_r    <= {9'd0, lim_pl_r};
          mb_r    <= {1'b0, ax_r};
          state_r <= ST_SH1;
        end
        ST_SH1: begin
          mb_r    <= {1'b0, ay_r};
          state_r <= ST_SH2;
        end
        ST_SH2: begin
          quo_r   <= prod_r[55:0];
          rem_r   <= '0;
          dvs_r   <= res_r[31:0];
          cnt_r   <= 6'd0;
          ret_r   <= ST_SH3;
          state_r <= ST_DIV;
        end
        ST_SH3: begin
          shx_r   <= quo_r[23:0];
          quo_r   <= prod_r[55:0];
          rem_r   <= '0;
          cnt_r   <= 6'd0;
          ret_r   <= ST_SH4;
          state_r <= ST_DIV;
        end
        ST_SH4: begin
          shy_r   <= quo_r[23:0];
          axis_r  <= AXIS_Z;
          state_r <= ST_PID0;
        end
        // derivative divide, integrator and history update
        ST_PID0: begin
          dneg_r <= diff[32];
          quo_r  <= {7'd0, dmag, 16'd0};
          rem_r  <= '0;
          dvs_r  <= {16'd0, dt_r};
          cnt_r  <= 6'd0;
          case (axis_r)
            AXIS_Z: begin
              sum_z_r  <= sum_cl[47:0];
              prev_z_r <= err_sel;
              first_r  <= 1'b0;
            end
            AXIS_X: begin
              sum_x_r  <= sum_cl[47:0];
              prev_x_r <= err_sel;
            end
            default: begin
              sum_y_r  <= sum_cl[47:0];
              prev_y_r <= err_sel;
            end
          endcase
          ret_r   <= ST_PID1;
          state_r <= ST_DIV;
        end
        ST_PID1: begin
          deriv_r <= dneg_r ? -$signed({1'b0, quo_r[48:0]}) : $signed({1'b0, quo_r[48:0]});
          tk_r    <= 2'd0;
          u_r     <= '0;
          state_r <= ST_TRM0;
        end
        // one gain product in two partial products
        ST_TRM0: begin
          aneg_r  <= op_a[49];
          maghi_r <= op_mag[49:25];
          ma_r    <= {8'd0, op_mag[24:0]};
          mb_r    <= {9'd0, k_sel};
          state_r <= ST_TRM1;
        end
        ST_TRM1: begin
          ma_r    <= {8'd0, maghi_r};
          state_r <= ST_TRM2;
        end
        ST_TRM2: begin
          pl_r    <= prod_r[48:0];
          state_r <= ST_TRM3;
        end
        ST_TRM3: begin
          pp_r    <= {prod_r[49:0], 25'd0} + 75'(pl_r);
          state_r <= ST_TRM4;
        end
        ST_TRM4: begin
          u_r  <= u_r + term_v;
          tk_r <= tk_r + 2'd1;
          if (tk_r == 2'd2) begin
            state_r <= ST_PIDEND;
          end else begin
            state_r <= ST_TRM0;
          end
        end
        // clamp and write the command
        ST_PIDEND: begin
          case (axis_r)
            AXIS_Z: begin
              cmd_z_r <= u_cl;
              axis_r  <= AXIS_X;
              state_r <= ST_PID0;
            end
            AXIS_X: begin
              cmd_x_r <= u_cl;
              axis_r  <= AXIS_Y;
              state_r <= ST_PID0;
            end
            default: begin
              cmd_y_r     <= u_cl;
              out_x_r     <= cmd_x_r;
              out_y_r     <= u_cl;
              out_z_r     <= cmd_z_r;
              out_valid_r <= 1'b1;
              axis_r      <= AXIS_Z;
              state_r     <= ST_IDLE;
            end
          endcase
        end
        // restoring divider, one quotient bit a cycle
        ST_DIV: begin
          rem_r <= dge ? dsub[31:0] : dtry[31:0];
          quo_r <= {quo_r[54:0], dge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(dxpid_pkg::DIV_ITERS - 1)) begin
            state_r <= ret_r;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: test/drone_xyz_pid_velocity_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drone_xyz_pid_velocity_controller_tb
// Self-checking bench for the three-axis velocity controller. Ticks are sent
// through the input channel, and a cycle-free model of the controller tracks
// the integrators, previous errors and last commands to predict every result.
// The run walks through several gain and limit settings and several patterns
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module drone_xyz_pid_velocity_controller_tb;

  // register indexes
  localparam logic [2:0] REG_KP_PLANAR   = 3'd0;
  localparam logic [2:0] REG_KI_PLANAR   = 3'd1;
  localparam logic [2:0] REG_KD_PLANAR   = 3'd2;
  localparam logic [2:0] REG_KP_VERT     = 3'd3;
  localparam logic [2:0] REG_KI_VERT     = 3'd4;
  localparam logic [2:0] REG_KD_VERT     = 3'd5;
  localparam logic [2:0] REG_PLANAR_LIM  = 3'd6;
  localparam logic [2:0] REG_VERT_LIM    = 3'd7;
  localparam int         NUM_REGS        = 8;

  localparam longint ACC_MAX   = 64'sd140737488355327;
  localparam longint ACC_MIN   = -64'sd140737488355328;
  localparam longint TERM_CAP  = 64'sd70368744177664;
  localparam longint ROT_GAIN  = 64'sd652032874;
  localparam longint PI_Q13    = 25736;
  localparam longint HPI_Q13   = 12868;
  localparam longint TWO_PI_Q13 = 51472;

  typedef struct {
    logic signed [31:0] goal_x, goal_y, goal_z;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] heading;
    logic        [15:0] elapsed;
  } tick_t;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
  } cmd_t;

  // ---------------------------------------------------------------------------
  // controller model and expected command store
  // ---------------------------------------------------------------------------
  class velocity_scoreboard;
    logic [23:0] regs[NUM_REGS];
    bit          first_tick;
    int          prev_err[3];
    longint      err_sum[3];
    int          last_cmd[3];
    cmd_t        pending_cmds[$];
    int          mismatches;
    longint      atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2};

    function new();
      regs = '{65536, 0, 0, 65536, 0, 0, 131072, 32768};
      first_tick = 1;
      prev_err = '{0, 0, 0};
      err_sum  = '{0, 0, 0};
      last_cmd = '{0, 0, 0};
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] v);
      regs[idx] = v;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // gain times value in q16 with saturation on huge products
    function longint gain_term(logic [23:0] k, longint a);
      longint unsigned mag;
      mag = a < 0 ? -a : a;
      if (k != 0 && mag > (64'd1 << 62) / k) return a < 0 ? -TERM_CAP : TERM_CAP;
      return (a * longint'(k)) >>> 16;
    endfunction

    function int run_pid(int axis, int err, logic [15:0] dt, logic [23:0] kp,
                         logic [23:0] ki, logic [23:0] kd, longint lim);
      longint deriv, u;
      deriv = ((longint'(err) - longint'(prev_err[axis])) * 65536) / longint'(dt);
      err_sum[axis] = clip(err_sum[axis] + err, ACC_MIN, ACC_MAX);
      prev_err[axis] = err;
      u = gain_term(kp, err) + gain_term(ki, err_sum[axis]) + gain_term(kd, deriv);
      return int'(clip(u, -lim, lim));
    endfunction

    function void note_input(tick_t t);
      longint dx, dy, ez, ang, x, y, z, nx, c, s, ex, ey, shx, shy;
      longint unsigned ax, ay, r;
      bit neg;
      cmd_t e;
      if (t.elapsed != 0) begin
        dx = clip(longint'(t.goal_x) - longint'(t.pos_x), -(64'sd1 << 31), (64'sd1 << 31) - 1);
        dy = clip(longint'(t.goal_y) - longint'(t.pos_y), -(64'sd1 << 31), (64'sd1 << 31) - 1);
        ez = clip(longint'(t.goal_z) - longint'(t.pos_z), -(64'sd1 << 31), (64'sd1 << 31) - 1);
        // fold heading into +-pi/2 then rotate
        ang = t.heading;
        neg = 0;
        if (ang > PI_Q13) ang -= TWO_PI_Q13;
        if (ang < -PI_Q13) ang += TWO_PI_Q13;
        if (ang > HPI_Q13) begin
          ang -= PI_Q13;
          neg = 1;
        end else if (ang < -HPI_Q13) begin
          ang += PI_Q13;
          neg = 1;
        end
        x = ROT_GAIN;
        y = 0;
        z = ang * 8;
        for (int i = 0; i < 16; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= atan_tab[i];
          end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += atan_tab[i];
          end
          x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
        ex = clip((c * dx + s * dy) >>> 30, -(64'sd1 << 31), (64'sd1 << 31) - 1);
        ey = clip((c * dy - s * dx) >>> 30, -(64'sd1 << 31), (64'sd1 << 31) - 1);
        ax = ex < 0 ? -ex : ex;
        ay = ey < 0 ? -ey : ey;
        // split planar limit between body axes
        if (ey != 0) begin
          r = root(ax * ax + ay * ay);
          shx = (longint'(regs[REG_PLANAR_LIM]) * ax) / r;
          shy = (longint'(regs[REG_PLANAR_LIM]) * ay) / r;
        end else begin
          shx = regs[REG_PLANAR_LIM];
          shy = 0;
        end
        if (first_tick) begin
          prev_err[2] = int'(ez);
          first_tick = 0;
        end
        last_cmd[2] = run_pid(2, int'(ez), t.elapsed, regs[REG_KP_VERT], regs[REG_KI_VERT],
                              regs[REG_KD_VERT], regs[REG_VERT_LIM]);
        last_cmd[0] = run_pid(0, int'(ex), t.elapsed, regs[REG_KP_PLANAR],
                              regs[REG_KI_PLANAR], regs[REG_KD_PLANAR], shx);
        last_cmd[1] = run_pid(1, int'(ey), t.elapsed, regs[REG_KP_PLANAR],
                              regs[REG_KI_PLANAR], regs[REG_KD_PLANAR], shy);
      end
      e.vx = last_cmd[0];
      e.vy = last_cmd[1];
      e.vz = last_cmd[2];
      pending_cmds.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] vx, logic signed [31:0] vy,
                               logic signed [31:0] vz);
      cmd_t e;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: x=%0d y=%0d z=%0d", vx, vy, vz);
        return;
      end
      e = pending_cmds.pop_front();
      if (vx !== e.vx || vy !== e.vy || vz !== e.vz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("command mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                   e.vx, e.vy, e.vz, vx, vy, vz);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_goal_x, in_goal_y, in_goal_z;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [15:0] in_heading;
  logic        [15:0] in_elapsed;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_vel_x_cmd, out_vel_y_cmd, out_vel_z_cmd;
  logic               cfg_we;
  logic        [2:0]  cfg_index;
  logic        [23:0] cfg_data;

  velocity_scoreboard sb;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  drone_xyz_pid_velocity_controller i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_goal_x     (in_goal_x),
    .in_goal_y     (in_goal_y),
    .in_goal_z     (in_goal_z),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_heading    (in_heading),
    .in_elapsed    (in_elapsed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_vel_x_cmd (out_vel_x_cmd),
    .out_vel_y_cmd (out_vel_y_cmd),
    .out_vel_z_cmd (out_vel_z_cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 100 MHz clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result beats are checked as they leave, ready toggles at random
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_vel_x_cmd, out_vel_y_cmd, out_vel_z_cmd);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one tick, keeping valid high afterwards
  task automatic send_tick(tick_t t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_goal_x  <= t.goal_x;
    in_goal_y  <= t.goal_y;
    in_goal_z  <= t.goal_z;
    in_pos_x   <= t.pos_x;
    in_pos_y   <= t.pos_y;
    in_pos_z   <= t.pos_z;
    in_heading <= t.heading;
    in_elapsed <= t.elapsed;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t);
  endtask

  // drop valid and wait until every expected command has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_regs(logic [23:0] vals[NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(i[2:0], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.goal_x = pick_coord();
    t.goal_y = pick_coord();
    t.goal_z = pick_coord();
    t.pos_x = $urandom_range(3) == 0 ? t.goal_x : pick_coord();
    t.pos_y = $urandom_range(3) == 0 ? t.goal_y : pick_coord();
    t.pos_z = pick_coord();
    t.heading = 16'($urandom_range(51472) - 25736);
    case ($urandom_range(19))
      0:       t.elapsed = 16'd0;
      1, 2:    t.elapsed = 16'($urandom);
      3:       t.elapsed = $urandom_range(1) ? 16'd1 : 16'hffff;
      default: t.elapsed = 16'($urandom_range(7000, 1000));
    endcase
    return t;
  endfunction

  function automatic tick_t make_tick(int gx, int gy, int gz, int px, int py, int pz,
                                      int hd, int dt);
    tick_t t;
    t.goal_x = gx; t.goal_y = gy; t.goal_z = gz;
    t.pos_x = px;  t.pos_y = py;  t.pos_z = pz;
    t.heading = 16'(hd); t.elapsed = 16'(dt);
    return t;
  endfunction

  // run limit
  initial begin
    #40ms;
    $display("drone_xyz_pid_velocity_controller_tb: errors");
    $finish;
  end

  initial begin
    logic [23:0] vals[NUM_REGS];
    int          count;
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_goal_x  <= '0; in_goal_y <= '0; in_goal_z <= '0;
    in_pos_x   <= '0; in_pos_y  <= '0; in_pos_z  <= '0;
    in_heading <= '0; in_elapsed <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at reset settings
    send_tick(make_tick(65536, 0, 65536, 0, 0, 0, 0, 0));           // zero time before first
    send_tick(make_tick(65536, 0, 131072, 0, 0, 0, 0, 3277));       // first tick, no body y
    send_tick(make_tick(65536, 0, 131072, 0, 0, 0, 0, 0));          // repeat last commands
    send_tick(make_tick(65536, 65536, 0, 0, 0, 65536, 12868, 3277));
    send_tick(make_tick(65536, 65536, 0, 0, 0, 65536, -12868, 3277));
    send_tick(make_tick(-65536, 32768, 0, 0, 0, 0, 25736, 1));
    send_tick(make_tick(-65536, 32768, 0, 0, 0, 0, -25736, 65535));
    send_tick(make_tick(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000, 25735, 1));
    send_tick(make_tick(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -25735, 1));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 6434, 65535));
    send_tick(make_tick(32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 0, 100));
    send_tick(make_tick(-32'h00050000, 32'h00030000, 32'h12340000, 0, 0, -32'h12340000,
                        -6000, 3277));
    drain();

    // phases: settings and idling pattern change between them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       vals = '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                          24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff};
        2:       vals = '{0, 0, 0, 0, 0, 0, 0, 0};
        3:       vals = '{65536, 0, 0, 65536, 0, 0, 131072, 32768};
        default: begin
          for (int i = 0; i < NUM_REGS; i++) vals[i] = 24'($urandom_range(24'h3ffff));
          vals[REG_KI_PLANAR] = 24'($urandom_range(24'h3fff));
          vals[REG_KI_VERT]   = 24'($urandom_range(24'h3fff));
        end
      endcase
      write_regs(vals);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      count = (ph == 2) ? 60 : 320;
      for (int n = 0; n < count; n++) begin
        // stretches of no idling in the phases with heavy sender gaps or receiver stalls
        if (n == count / 2) begin
          send_idle_pct  = (ph % 4 == 1) ? 0 : send_idle_pct;
          recv_stall_pct = (ph % 4 == 2) ? 0 : recv_stall_pct;
        end
        send_tick(random_tick());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_cmds.size() == 0) begin
      $display("drone_xyz_pid_velocity_controller_tb: clean");
    end else begin
      $display("drone_xyz_pid_velocity_controller_tb: errors");
    end
    $finish;
  end

endmodule
